// ===== hdl/bmpq_pkg.sv =====
package bmpq_pkg;

  localparam int OP_W     = 1;
  localparam int LEVEL_W  = 5;
  localparam int TASK_W   = 16;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_BAD_LEVEL = 2'd2;
  localparam status_t ST_IDLE      = 2'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

endpackage

// ===== hdl/bmpq_ram.sv =====
module bmpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bmpq_ffs.sv =====
module bmpq_ffs #(
  parameter int N = 32
) (
  input  logic [N-1:0]         map,
  output logic                 found,
  output logic [$clog2(N)-1:0] idx
);

  logic [N-1:0] lowest;

  // isolate the lowest set bit, then encode the one-hot result
  assign lowest = map & (~map + N'(1));
  assign found  = |map;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        idx = idx | ($clog2(N))'(i);
      end
    end
  end

endmodule

// ===== hdl/bitmap_multilevel_priority_queue.sv =====
// a result is registered and appears in the cycle after its input transaction is accepted
// throughput: one push or pop per cycle while the output side takes results
// the rate is set by the single result register and the registered read of the handle store
// reset (synchronous, active high) empties every level and clears the bitmap
// and the result valid flag; handle store contents are left as they are
module bitmap_multilevel_priority_queue
  import bmpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 32,
  parameter int LEVEL_DEPTH = 8,
  parameter int ID_WIDTH    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // op, task_level, task_id
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // status, out_task_id, served_level
);

  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW  = $clog2(MEM_DEPTH);

  logic [HW-1:0]         head  [NUM_LEVELS];
  logic [CW-1:0]         count [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] map;

  logic                  valid1;
  status_t               status1;
  logic [LEVEL_W-1:0]    served1;
  logic                  pop_ok1;

  logic                  in_op;
  logic [LEVEL_W-1:0]    in_level;
  logic [TASK_W-1:0]     in_id;
  logic                  acc;
  logic                  found;
  logic [LW-1:0]         pop_lvl;
  logic [LW-1:0]         sel_lvl;
  logic [HW-1:0]         sel_head;
  logic [CW-1:0]         sel_count;
  logic                  level_ok;
  logic                  full;
  logic                  push_ok;
  logic                  pop_ok;
  logic [CW:0]           slot_sum;
  logic [HW-1:0]         slot;
  logic [HW-1:0]         head_inc;
  logic [HW-1:0]         ram_slot;
  logic [AW-1:0]         addr;
  status_t               status_next;
  logic [LEVEL_W-1:0]    served_next;
  logic [63:0]           id_wide;
  logic [ID_WIDTH-1:0]   wdata;
  logic [ID_WIDTH-1:0]   rdata;
  logic [63:0]           rd_wide;
  logic [TASK_W-1:0]     out_id;

  assign in_op    = s_tdata[0];
  assign in_level = s_tdata[OP_W +: LEVEL_W];
  assign in_id    = s_tdata[OP_W + LEVEL_W +: TASK_W];

  assign s_tready = !valid1 || m_tready;
  assign acc      = s_tvalid && s_tready;

  bmpq_ffs #(
    .N (NUM_LEVELS)
  ) u_ffs (
    .map   (map),
    .found (found),
    .idx   (pop_lvl)
  );

  always_comb begin
    sel_lvl   = (in_op == OP_POP) ? pop_lvl : LW'(in_level);
    sel_head  = head[sel_lvl];
    sel_count = count[sel_lvl];
    level_ok  = (in_level != '0) && (32'(in_level) < NUM_LEVELS);
    full      = (sel_count == CW'(LEVEL_DEPTH));
    push_ok   = (in_op == OP_PUSH) && level_ok && !full;
    pop_ok    = (in_op == OP_POP) && found;

    slot_sum = (CW + 1)'(sel_head) + (CW + 1)'(sel_count);
    if (32'(slot_sum) >= LEVEL_DEPTH) begin
      slot = HW'(32'(slot_sum) - LEVEL_DEPTH);
    end else begin
      slot = HW'(slot_sum);
    end

    if (32'(sel_head) + 1 >= LEVEL_DEPTH) begin
      head_inc = '0;
    end else begin
      head_inc = sel_head + HW'(1);
    end

    ram_slot = (in_op == OP_POP) ? sel_head : slot;
    addr     = AW'(32'(sel_lvl) * LEVEL_DEPTH + 32'(ram_slot));

    if (in_op == OP_PUSH) begin
      if (!level_ok) begin
        status_next = ST_BAD_LEVEL;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else begin
      status_next = found ? ST_OK : ST_IDLE;
    end
    served_next = pop_ok ? LEVEL_W'(pop_lvl) : '0;

    id_wide = 64'(in_id);
    wdata   = id_wide[ID_WIDTH-1:0];
  end

  bmpq_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (acc && push_ok),
    .waddr (addr),
    .wdata (wdata),
    .re    (acc && pop_ok),
    .raddr (addr),
    .rdata (rdata)
  );

  // level bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      map <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else if (acc) begin
      if (push_ok) begin
        count[sel_lvl] <= sel_count + CW'(1);
        map[sel_lvl]   <= 1'b1;
      end else if (pop_ok) begin
        head[sel_lvl]  <= head_inc;
        count[sel_lvl] <= sel_count - CW'(1);
        if (sel_count == CW'(1)) begin
          map[sel_lvl] <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (acc) begin
      valid1 <= 1'b1;
    end else if (m_tready) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status1 <= status_next;
      served1 <= served_next;
      pop_ok1 <= pop_ok;
    end
  end

  assign rd_wide  = 64'(rdata);
  assign out_id   = pop_ok1 ? rd_wide[TASK_W-1:0] : '0;
  assign m_tvalid = valid1;
  assign m_tdata  = {1'b0, served1, out_id, status1};

endmodule
